@@ hdl/bdws_pkg.sv @@
package bdws_pkg;

    localparam int DATA_W       = 32;
    localparam int KIND_W       = 3;
    localparam int OCC_W        = 7;
    localparam int CAPACITY_DEF = 64;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_DELETE     = 3'd4,
        KIND_SEARCH     = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_SHIFT,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [DATA_W-1:0] popped;
        logic              found;
        status_t           status;
        logic [OCC_W-1:0]  occupancy;
    } res_t;

endpackage

@@ hdl/bdws_ram.sv @@
module bdws_ram #(
    parameter int DEPTH  = bdws_pkg::CAPACITY_DEF,
    parameter int ADDR_W = $clog2(bdws_pkg::CAPACITY_DEF),
    parameter int DATA_W = bdws_pkg::DATA_W
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/bdws_ctrl.sv @@
module bdws_ctrl #(
    parameter int CAPACITY = bdws_pkg::CAPACITY_DEF,
    localparam int IDX_W = $clog2(CAPACITY),
    localparam int CNT_W = $clog2(CAPACITY + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [bdws_pkg::KIND_W-1:0]   kind,
    input  logic [bdws_pkg::DATA_W-1:0]   item_value,
    output logic                          ram_we,
    output logic [IDX_W-1:0]              ram_waddr,
    output logic [bdws_pkg::DATA_W-1:0]   ram_wdata,
    output logic                          ram_re,
    output logic [IDX_W-1:0]              ram_raddr,
    input  logic [bdws_pkg::DATA_W-1:0]   ram_rdata,
    input  logic                          out_free,
    output logic                          res_load,
    output bdws_pkg::res_t                res
);

    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
    localparam logic [CNT_W:0]   CAP_S = (CNT_W + 1)'(CAPACITY);

    bdws_pkg::state_t  state_reg, state_next;
    logic [IDX_W-1:0]  front_reg, front_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [bdws_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [bdws_pkg::DATA_W-1:0] word_reg, word_next;
    logic [CNT_W-1:0]  off_reg, off_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  rd_addr_reg, rd_addr_next;
    logic [IDX_W-1:0]  wr_addr_reg, wr_addr_next;
    logic              fnd_reg, fnd_next;
    bdws_pkg::status_t sts_reg, sts_next;
    logic              popok_reg, popok_next;

    logic [CNT_W-1:0]  slot_off;
    logic [CNT_W:0]    slot_sum;
    logic [IDX_W-1:0]  slot_addr;
    logic              full;
    logic              empty;
    logic              more;
    logic              match;

    // shared ring address unit: (front + offset) mod CAPACITY
    assign slot_sum  = {{(CNT_W + 1 - IDX_W){1'b0}}, front_reg} + {1'b0, slot_off};
    assign slot_addr = (slot_sum >= CAP_S) ? IDX_W'(slot_sum - CAP_S) : IDX_W'(slot_sum);

    assign full  = (count_reg >= CAP_C);
    assign empty = (count_reg == '0);
    assign more  = (off_reg < count_reg);
    assign match = pend_reg && (ram_rdata == word_reg);

    assign req_stall = (state_reg != bdws_pkg::ST_IDLE);

    always_comb
    begin
        slot_off = '0;
        case (state_reg)
            bdws_pkg::ST_EXEC:
            begin
                case (kind_reg)
                    bdws_pkg::KIND_PUSH_FRONT: slot_off = CAP_C - CNT_W'(1);
                    bdws_pkg::KIND_PUSH_BACK:  slot_off = count_reg;
                    bdws_pkg::KIND_POP_FRONT:  slot_off = CNT_W'(1);
                    bdws_pkg::KIND_POP_BACK:   slot_off = count_reg - CNT_W'(1);
                    default:                   slot_off = '0;
                endcase
            end
            bdws_pkg::ST_SCAN, bdws_pkg::ST_SHIFT: slot_off = off_reg;
            default: slot_off = '0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bdws_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = bdws_pkg::ST_EXEC;
                end
            end
            bdws_pkg::ST_EXEC:
            begin
                case (kind_reg)
                    bdws_pkg::KIND_DELETE:
                        state_next = empty ? bdws_pkg::ST_FIN : bdws_pkg::ST_SCAN;
                    bdws_pkg::KIND_SEARCH:
                        state_next = bdws_pkg::ST_SCAN;
                    default:
                        state_next = bdws_pkg::ST_FIN;
                endcase
            end
            bdws_pkg::ST_SCAN:
            begin
                if (match)
                begin
                    state_next = (kind_reg == bdws_pkg::KIND_DELETE) ?
                                 bdws_pkg::ST_SHIFT : bdws_pkg::ST_FIN;
                end
                else if (!more)
                begin
                    state_next = bdws_pkg::ST_FIN;
                end
            end
            bdws_pkg::ST_SHIFT:
            begin
                if (!more)
                begin
                    state_next = bdws_pkg::ST_FIN;
                end
            end
            bdws_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = bdws_pkg::ST_IDLE;
                end
            end
            default: state_next = bdws_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        front_next   = front_reg;
        count_next   = count_reg;
        kind_next    = kind_reg;
        word_next    = word_reg;
        off_next     = off_reg;
        pend_next    = pend_reg;
        rd_addr_next = rd_addr_reg;
        wr_addr_next = wr_addr_reg;
        fnd_next     = fnd_reg;
        sts_next     = sts_reg;
        popok_next   = popok_reg;
        ram_we       = 1'b0;
        ram_waddr    = slot_addr;
        ram_wdata    = word_reg;
        ram_re       = 1'b0;
        ram_raddr    = slot_addr;
        res_load     = 1'b0;

        case (state_reg)
            bdws_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next  = kind;
                    word_next  = item_value;
                    fnd_next   = 1'b0;
                    sts_next   = bdws_pkg::STS_OK;
                    popok_next = 1'b0;
                    off_next   = '0;
                    pend_next  = 1'b0;
                end
            end
            bdws_pkg::ST_EXEC:
            begin
                case (kind_reg)
                    bdws_pkg::KIND_PUSH_FRONT, bdws_pkg::KIND_PUSH_BACK:
                    begin
                        if (full)
                        begin
                            sts_next = bdws_pkg::STS_FULL;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                            if (kind_reg == bdws_pkg::KIND_PUSH_FRONT)
                            begin
                                front_next = slot_addr;
                            end
                        end
                    end
                    bdws_pkg::KIND_POP_FRONT, bdws_pkg::KIND_POP_BACK:
                    begin
                        if (empty)
                        begin
                            sts_next = bdws_pkg::STS_EMPTY;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            popok_next = 1'b1;
                            count_next = count_reg - CNT_W'(1);
                            if (kind_reg == bdws_pkg::KIND_POP_FRONT)
                            begin
                                ram_raddr  = front_reg;
                                front_next = slot_addr;
                            end
                        end
                    end
                    bdws_pkg::KIND_DELETE:
                    begin
                        if (empty)
                        begin
                            sts_next = bdws_pkg::STS_EMPTY;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            bdws_pkg::ST_SCAN:
            begin
                // read of offset k overlaps the compare of offset k-1
                if (match)
                begin
                    fnd_next  = 1'b1;
                    pend_next = 1'b0;
                end
                else if (more)
                begin
                    ram_re       = 1'b1;
                    rd_addr_next = slot_addr;
                    pend_next    = 1'b1;
                    off_next     = off_reg + CNT_W'(1);
                end
            end
            bdws_pkg::ST_SHIFT:
            begin
                // move entry j+1 down to j; the write comes in the cycle after its read
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wr_addr_reg;
                    ram_wdata = ram_rdata;
                end
                if (more)
                begin
                    ram_re       = 1'b1;
                    wr_addr_next = rd_addr_reg;
                    rd_addr_next = slot_addr;
                    pend_next    = 1'b1;
                    off_next     = off_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next  = 1'b0;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            bdws_pkg::ST_FIN:
            begin
                res_load = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        res.popped    = popok_reg ? ram_rdata : '0;
        res.found     = fnd_reg;
        res.status    = sts_reg;
        res.occupancy = bdws_pkg::OCC_W'(count_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bdws_pkg::ST_IDLE;
            front_reg <= '0;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        word_reg    <= word_next;
        off_reg     <= off_next;
        rd_addr_reg <= rd_addr_next;
        wr_addr_reg <= wr_addr_next;
        fnd_reg     <= fnd_next;
        sts_reg     <= sts_next;
        popok_reg   <= popok_next;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("occupancy above capacity");

    a_rw_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re && (ram_waddr == ram_raddr)))
        else $error("read and write to the same slot");

    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bdws_pkg::ST_EXEC && count_reg == CAP_C &&
         (kind_reg == bdws_pkg::KIND_PUSH_FRONT || kind_reg == bdws_pkg::KIND_PUSH_BACK))
        |=> (count_reg == $past(count_reg) && front_reg == $past(front_reg) &&
             sts_reg == bdws_pkg::STS_FULL))
        else $error("push on full queue changed state");

    a_delete_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bdws_pkg::ST_SHIFT && !more)
        |=> (count_reg == $past(count_reg) - CNT_W'(1) && state_reg == bdws_pkg::ST_FIN))
        else $error("delete did not remove one entry");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> (state_reg == bdws_pkg::ST_IDLE))
        else $error("result loaded without returning to idle");
`endif

endmodule

@@ hdl/bounded_deque_with_search.sv @@
// Bounded double-ended queue of CAPACITY signed 32-bit words in a ring buffer,
// with push/pop at both ends, delete of the first match (counted from the
// front) and search. One request is worked at a time; every request returns
// one transfer with the popped word, found flag, status and occupancy.
// Pushes, pops, a delete on an empty queue and unused kind codes pass from
// the execute state straight to the finish state. A search compares entries
// from the front until one matches or none is left; a delete on a non-empty
// queue does the same and, when it finds a match, shifts every later entry
// down by one slot. The single read port of the entry RAM lets one entry be
// compared or moved per cycle through a shared ring-address adder. A finished
// result sits in an output register, so the next request is taken while it
// waits. Entries are not cleared at reset; only stored entries are ever read.
module bounded_deque_with_search #(
    parameter int CAPACITY = bdws_pkg::CAPACITY_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic [bdws_pkg::KIND_W-1:0]       kind,
    input  logic signed [bdws_pkg::DATA_W-1:0] item_value,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic signed [bdws_pkg::DATA_W-1:0] popped_value,
    output logic                              found,
    output logic [1:0]                        status,
    output logic [bdws_pkg::OCC_W-1:0]        occupancy
);

    localparam int IDX_W = $clog2(CAPACITY);

    logic                        ram_we;
    logic [IDX_W-1:0]            ram_waddr;
    logic [bdws_pkg::DATA_W-1:0] ram_wdata;
    logic                        ram_re;
    logic [IDX_W-1:0]            ram_raddr;
    logic [bdws_pkg::DATA_W-1:0] ram_rdata;
    logic                        out_free;
    logic                        res_load;
    bdws_pkg::res_t              res;
    bdws_pkg::res_t              res_reg;
    logic                        rsp_valid_reg, rsp_valid_next;

    bdws_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .kind       (kind),
        .item_value ($unsigned(item_value)),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .out_free   (out_free),
        .res_load   (res_load),
        .res        (res)
    );

    bdws_ram #(
        .DEPTH  (CAPACITY),
        .ADDR_W (IDX_W),
        .DATA_W (bdws_pkg::DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign popped_value = $signed(res_reg.popped);
    assign found        = res_reg.found;
    assign status       = res_reg.status;
    assign occupancy    = res_reg.occupancy;

endmodule
